@@ rtl/npq_pkg.sv @@
// Shared constants, types and helper functions for the nearest palette quantizer.
// Used by npq_search and nearest_palette_quantizer; depends on nothing else.
`default_nettype none

package npq_pkg;

	localparam int PALETTE_ENTRIES = 256;
	localparam int MEMO_ENTRIES    = 32768;

	localparam int CHAN_W  = 8;
	localparam int IDX_W   = 8;
	localparam int SIZE_W  = 9;
	localparam int RGB_W   = 3 * CHAN_W;
	localparam int KEY_BITS = 5;
	localparam int SQ_W    = 2 * CHAN_W;
	localparam int DIST_W  = SQ_W + 2;

	localparam int PAL_AW  = $clog2(PALETTE_ENTRIES);
	localparam int CNT_W   = $clog2(PALETTE_ENTRIES + 1);
	localparam int MEMO_AW = $clog2(MEMO_ENTRIES);
	localparam int MEMO_W  = IDX_W + 1;

	localparam logic [SIZE_W-1:0] PAL_SIZE_MAX = SIZE_W'(PALETTE_ENTRIES);

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_PIXEL = 1'b1;

	typedef struct packed {
		logic              en;
		logic [PAL_AW-1:0] addr;
		logic [RGB_W-1:0]  data;
	} pal_wr_t;

	typedef struct packed {
		logic              start;
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic [CNT_W-1:0]  limit;
	} srch_req_t;

	typedef struct packed {
		logic              done;
		logic [PAL_AW-1:0] index;
	} srch_rsp_t;

	function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
			input logic [CHAN_W-1:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

	function automatic logic [SQ_W-1:0] square(input logic [CHAN_W-1:0] d);
		logic [SQ_W-1:0] w;
		w = SQ_W'(d);
		return w * w;
	endfunction

endpackage

`default_nettype wire

@@ rtl/npq_ram.sv @@
// Generic simple dual-port RAM with one write port and one registered read port.
// Standalone; instantiated for the palette and the memo.
`default_nettype none

module npq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

@@ rtl/npq_search.sv @@
// Palette store and nearest-entry search unit: walks entries one per cycle.
// Depends on npq_pkg and npq_ram.
`default_nettype none

module npq_search
	import npq_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire pal_wr_t   pal_wr,
	input  wire srch_req_t req,
	output srch_rsp_t      rsp
);

	logic [RGB_W-1:0]  pal_rdata;
	logic              busy_q;
	logic [CNT_W-1:0]  issue_q;
	logic [CNT_W-1:0]  limit_q;
	logic              issue;
	logic              done;
	logic              v_s1;
	logic [PAL_AW-1:0] idx_s1;
	logic              v_s2;
	logic [PAL_AW-1:0] idx_s2;
	logic [SQ_W-1:0]   sq_r_s2;
	logic [SQ_W-1:0]   sq_g_s2;
	logic [SQ_W-1:0]   sq_b_s2;
	logic [DIST_W-1:0] cand_dist;
	logic              have_q;
	logic [PAL_AW-1:0] best_q;
	logic [DIST_W-1:0] best_dist_q;

	npq_ram #(
		.WIDTH(RGB_W),
		.DEPTH(PALETTE_ENTRIES)
	) u_palette (
		.clk  (clk),
		.we   (pal_wr.en),
		.waddr(pal_wr.addr),
		.wdata(pal_wr.data),
		.raddr(issue_q[PAL_AW-1:0]),
		.rdata(pal_rdata)
	);

	assign issue     = busy_q && (issue_q < limit_q);
	assign done      = busy_q && !issue && !v_s1 && !v_s2;
	assign cand_dist = DIST_W'(sq_r_s2) + DIST_W'(sq_g_s2) + DIST_W'(sq_b_s2);

	assign rsp.done  = done;
	assign rsp.index = best_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			issue_q     <= '0;
			limit_q     <= '0;
			v_s1        <= 1'b0;
			idx_s1      <= '0;
			v_s2        <= 1'b0;
			idx_s2      <= '0;
			sq_r_s2     <= '0;
			sq_g_s2     <= '0;
			sq_b_s2     <= '0;
			have_q      <= 1'b0;
			best_q      <= '0;
			best_dist_q <= '0;
		end else begin
			v_s1    <= issue;
			idx_s1  <= issue_q[PAL_AW-1:0];
			v_s2    <= v_s1;
			idx_s2  <= idx_s1;
			sq_r_s2 <= square(abs_diff(req.red,   pal_rdata[3*CHAN_W-1:2*CHAN_W]));
			sq_g_s2 <= square(abs_diff(req.green, pal_rdata[2*CHAN_W-1:CHAN_W]));
			sq_b_s2 <= square(abs_diff(req.blue,  pal_rdata[CHAN_W-1:0]));
			if (req.start) begin
				busy_q  <= 1'b1;
				issue_q <= '0;
				limit_q <= req.limit;
				have_q  <= 1'b0;
				best_q  <= '0;
			end else begin
				if (issue) begin
					issue_q <= issue_q + 1'b1;
				end
				if (done) begin
					busy_q <= 1'b0;
				end
				if (v_s2 && (!have_q || cand_dist < best_dist_q)) begin
					have_q      <= 1'b1;
					best_q      <= idx_s2;
					best_dist_q <= cand_dist;
				end
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/nearest_palette_quantizer.sv @@
// Top level of the nearest palette quantizer: control, memo store and output register.
// Depends on npq_pkg, npq_ram and npq_search.
//
//   Channel  Handshake            Payload
//   in       in_valid / in_stall  req_type, entry_index, red, green, blue
//   out      out_valid / out_stall colour_index, memo_hit
//   cfg      cfg_valid / cfg_ready palette_size
//
// A load item is written into the palette when it is accepted. A pixel item that hits
// the memo is answered from it. A miss walks the palette through one read port, one
// entry per cycle, and stores the index it finds in the memo. Before the first pixel
// after reset, and when palette_size differs from the count the memo was built for, a
// clearing pass over all 32768 memo entries and one memo read state come first.
// A stalled output holds the next result.
`default_nettype none

module nearest_palette_quantizer
	import npq_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic              req_type,
	input  wire logic [7:0]        entry_index,
	input  wire logic [7:0]        red,
	input  wire logic [7:0]        green,
	input  wire logic [7:0]        blue,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic      [7:0]        colour_index,
	output logic                   memo_hit,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [SIZE_W-1:0] palette_size
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CLEAR,
		S_READ,
		S_CHECK,
		S_SEARCH,
		S_DELIVER
	} state_t;

	localparam logic [MEMO_AW-1:0] CLR_LAST = MEMO_AW'(MEMO_ENTRIES - 1);

	state_t              state_q;
	logic [SIZE_W-1:0]   palette_size_q;
	logic [SIZE_W-1:0]   memo_count_q;
	logic                memo_dirty_q;
	logic [MEMO_AW-1:0]  clr_q;
	logic [MEMO_AW-1:0]  key_q;
	logic [CHAN_W-1:0]   red_q;
	logic [CHAN_W-1:0]   green_q;
	logic [CHAN_W-1:0]   blue_q;
	logic [IDX_W-1:0]    res_q;
	logic                res_hit_q;
	logic                out_valid_q;
	logic [IDX_W-1:0]    colour_index_q;
	logic                memo_hit_q;
	logic                out_free;
	logic                out_load;
	logic [MEMO_AW-1:0]  key_in;
	logic [MEMO_AW-1:0]  memo_raddr;
	logic                memo_we;
	logic [MEMO_AW-1:0]  memo_waddr;
	logic [MEMO_W-1:0]   memo_wdata;
	logic [MEMO_W-1:0]   memo_rdata;
	logic [SIZE_W-1:0]   size_lim;
	pal_wr_t             pal_wr;
	srch_req_t           srch_req;
	srch_rsp_t           srch_rsp;

	assign in_stall     = (state_q != S_IDLE);
	assign cfg_ready    = 1'b1;
	assign out_valid    = out_valid_q;
	assign colour_index = colour_index_q;
	assign memo_hit     = memo_hit_q;
	assign out_free     = !out_valid_q || !out_stall;
	assign out_load     = out_free && (((state_q == S_CHECK) && memo_rdata[IDX_W])
		|| ((state_q == S_SEARCH) && srch_rsp.done) || (state_q == S_DELIVER));

	assign key_in = MEMO_AW'({red[CHAN_W-1 -: KEY_BITS], green[CHAN_W-1 -: KEY_BITS],
		blue[CHAN_W-1 -: KEY_BITS]});
	assign memo_raddr = (state_q == S_IDLE) ? key_in : key_q;

	assign pal_wr.en   = in_valid && !in_stall && (req_type == REQ_LOAD)
		&& ({1'b0, entry_index} < PAL_SIZE_MAX);
	assign pal_wr.addr = entry_index[PAL_AW-1:0];
	assign pal_wr.data = {red, green, blue};

	assign size_lim = (palette_size_q > PAL_SIZE_MAX) ? PAL_SIZE_MAX : palette_size_q;

	assign srch_req.start = (state_q == S_CHECK) && !memo_rdata[IDX_W];
	assign srch_req.red   = red_q;
	assign srch_req.green = green_q;
	assign srch_req.blue  = blue_q;
	assign srch_req.limit = size_lim[CNT_W-1:0];

	always_comb begin
		memo_we    = 1'b0;
		memo_waddr = key_q;
		memo_wdata = {1'b1, IDX_W'(srch_rsp.index)};
		if (state_q == S_CLEAR) begin
			memo_we    = 1'b1;
			memo_waddr = clr_q;
			memo_wdata = '0;
		end else if ((state_q == S_SEARCH) && srch_rsp.done) begin
			memo_we = 1'b1;
		end
	end

	npq_ram #(
		.WIDTH(MEMO_W),
		.DEPTH(MEMO_ENTRIES)
	) u_memo (
		.clk  (clk),
		.we   (memo_we),
		.waddr(memo_waddr),
		.wdata(memo_wdata),
		.raddr(memo_raddr),
		.rdata(memo_rdata)
	);

	npq_search u_search (
		.clk   (clk),
		.arst_n(arst_n),
		.pal_wr(pal_wr),
		.req   (srch_req),
		.rsp   (srch_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			palette_size_q <= SIZE_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			palette_size_q <= palette_size;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			memo_count_q   <= '0;
			memo_dirty_q   <= 1'b1;
			clr_q          <= '0;
			key_q          <= '0;
			red_q          <= '0;
			green_q        <= '0;
			blue_q         <= '0;
			res_q          <= '0;
			res_hit_q      <= 1'b0;
			out_valid_q    <= 1'b0;
			colour_index_q <= '0;
			memo_hit_q     <= 1'b0;
		end else begin
			out_valid_q <= out_load || (out_valid_q && out_stall);
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && (req_type == REQ_PIXEL)) begin
						key_q   <= key_in;
						red_q   <= red;
						green_q <= green;
						blue_q  <= blue;
						if (memo_dirty_q || (palette_size_q != memo_count_q)) begin
							clr_q   <= '0;
							state_q <= S_CLEAR;
						end else begin
							state_q <= S_CHECK;
						end
					end
				end
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CLR_LAST) begin
						memo_count_q <= palette_size_q;
						memo_dirty_q <= 1'b0;
						state_q      <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (memo_rdata[IDX_W]) begin
						res_q     <= memo_rdata[IDX_W-1:0];
						res_hit_q <= 1'b1;
						if (out_free) begin
							colour_index_q <= memo_rdata[IDX_W-1:0];
							memo_hit_q     <= 1'b1;
							state_q        <= S_IDLE;
						end else begin
							state_q <= S_DELIVER;
						end
					end else begin
						state_q <= S_SEARCH;
					end
				end
				S_SEARCH: begin
					if (srch_rsp.done) begin
						res_q     <= IDX_W'(srch_rsp.index);
						res_hit_q <= 1'b0;
						if (out_free) begin
							colour_index_q <= IDX_W'(srch_rsp.index);
							memo_hit_q     <= 1'b0;
							state_q        <= S_IDLE;
						end else begin
							state_q <= S_DELIVER;
						end
					end
				end
				S_DELIVER: begin
					if (out_free) begin
						colour_index_q <= res_q;
						memo_hit_q     <= res_hit_q;
						state_q        <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

@@ tb/sv/nearest_palette_quantizer_tb.sv @@
// Self-checking testbench for nearest_palette_quantizer: a predictor of the palette search and
// its key memo checks every result against the expected colour index and hit flag.
// Depends only on npq_pkg and the RTL of the block.
`timescale 1ns / 100ps

module nearest_palette_quantizer_tb
	import npq_pkg::*;
();

	localparam int unsigned CYCLE_LIMIT = 6_000_000;

	typedef struct packed {
		logic [7:0] colour_index;
		logic       memo_hit;
	} colour_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic              req_type = REQ_LOAD;
	logic [7:0]        entry_index = '0;
	logic [7:0]        red = '0;
	logic [7:0]        green = '0;
	logic [7:0]        blue = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [7:0]        colour_index;
	logic              memo_hit;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [SIZE_W-1:0] palette_size = SIZE_W'(1);

	logic [23:0]       palette_rgb [PALETTE_ENTRIES];
	bit                memo_filled [MEMO_ENTRIES];
	logic [7:0]        memo_colour [MEMO_ENTRIES];
	logic [SIZE_W-1:0] memo_size = '0;
	logic [SIZE_W-1:0] search_size = SIZE_W'(1);
	colour_result_t    expected_colours [$];

	int unsigned       mismatches = 0;
	int unsigned       cycle_count = 0;
	int unsigned       stall_run = 0;
	bit                calm = 1'b0;

	nearest_palette_quantizer DUT (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int unsigned chan_sq(input logic [7:0] a, input logic [7:0] b);
		int d;
		d = int'(a) - int'(b);
		return d * d;
	endfunction

	function automatic logic [7:0] nearest_entry(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		int unsigned span;
		int unsigned score;
		int unsigned best_score;
		logic [7:0] best;
		span = (search_size > PALETTE_ENTRIES) ? PALETTE_ENTRIES : search_size;
		best = '0;
		best_score = 0;
		for (int unsigned c = 0; c < span; c++) begin
			score = chan_sq(r, palette_rgb[c][23:16]) + chan_sq(g, palette_rgb[c][15:8])
				+ chan_sq(b, palette_rgb[c][7:0]);
			if (c == 0 || score < best_score) begin
				best = 8'(c);
				best_score = score;
			end
		end
		return best;
	endfunction

	function automatic void apply_item(input logic rt, input logic [7:0] idx,
			input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		logic [14:0] key;
		colour_result_t res;
		if (rt == REQ_LOAD) begin
			palette_rgb[idx] = {r, g, b};
		end else begin
			if (search_size != memo_size) begin
				foreach (memo_filled[k]) memo_filled[k] = 1'b0;
				memo_size = search_size;
			end
			key = {r[7:3], g[7:3], b[7:3]};
			if (memo_filled[key]) begin
				res = '{memo_colour[key], 1'b1};
			end else begin
				res = '{nearest_entry(r, g, b), 1'b0};
				memo_filled[key] = 1'b1;
				memo_colour[key] = res.colour_index;
			end
			expected_colours.push_back(res);
		end
	endfunction

	task automatic send_item(input logic rt, input logic [7:0] idx, input logic [7:0] r,
			input logic [7:0] g, input logic [7:0] b);
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= rt;
		entry_index <= idx;
		red <= r;
		green <= g;
		blue <= b;
		do @(posedge clk); while (in_stall);
		apply_item(rt, idx, r, g, b);
	endtask

	task automatic send_load(input logic [7:0] idx, input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		send_item(REQ_LOAD, idx, r, g, b);
	endtask

	task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		send_item(REQ_PIXEL, 8'($urandom), r, g, b);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (expected_colours.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_palette_size(input logic [SIZE_W-1:0] value);
		settle();
		cfg_valid <= 1'b1;
		palette_size <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		search_size = value;
	endtask

	task automatic run_phase(input logic [SIZE_W-1:0] size, input int unsigned n_items);
		logic [14:0] pool [32];
		logic [14:0] key;
		int unsigned pick;
		write_palette_size(size);
		foreach (pool[i]) pool[i] = 15'($urandom);
		repeat (n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 15) begin
				send_load(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
			end else if (pick < 30) begin
				send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
			end else begin
				key = pool[$urandom_range(0, 31)];
				send_pixel({key[14:10], 3'($urandom)}, {key[9:5], 3'($urandom)},
					{key[4:0], 3'($urandom)});
			end
		end
	endtask

	task automatic test_default_size();
		send_load(8'd255, 8'd255, 8'd255, 8'd255);
		send_load(8'd0, 8'd0, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd3, 8'd5, 8'd7);
	endtask

	task automatic test_tie_break();
		write_palette_size(SIZE_W'(3));
		send_load(8'd0, 8'd100, 8'd100, 8'd100);
		send_load(8'd1, 8'd120, 8'd100, 8'd100);
		send_load(8'd2, 8'd255, 8'd0, 8'd0);
		send_pixel(8'd110, 8'd100, 8'd100);
		send_pixel(8'd121, 8'd100, 8'd100);
		send_pixel(8'd250, 8'd5, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd0);
	endtask

	task automatic test_zero_size();
		write_palette_size('0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd250, 8'd249, 8'd248);
		send_pixel(8'd0, 8'd0, 8'd0);
	endtask

	// Reloading the palette at an unchanged size must leave earlier answers in place.
	task automatic test_stale_memo();
		write_palette_size(SIZE_W'(2));
		send_pixel(8'd60, 8'd60, 8'd60);
		send_load(8'd0, 8'd250, 8'd250, 8'd250);
		send_load(8'd1, 8'd50, 8'd50, 8'd50);
		send_pixel(8'd61, 8'd62, 8'd63);
		send_pixel(8'd40, 8'd40, 8'd40);
	endtask

	task automatic test_full_palette();
		for (int e = 0; e < PALETTE_ENTRIES; e++)
			send_load(8'(e), 8'($urandom), 8'($urandom), 8'($urandom));
		run_phase(SIZE_W'(PALETTE_ENTRIES), 100);
	endtask

	task automatic test_oversized_size();
		run_phase(SIZE_W'(511), 60);
		run_phase(SIZE_W'(300), 60);
	endtask

	task automatic test_random_sizes();
		run_phase(SIZE_W'(1), 150);
		run_phase(SIZE_W'(2), 150);
		run_phase(SIZE_W'(7), 150);
		run_phase(SIZE_W'(16), 150);
		run_phase(SIZE_W'(33), 150);
		run_phase(SIZE_W'(100), 120);
		run_phase(SIZE_W'(255), 80);
		run_phase(SIZE_W'(255), 80);
	endtask

	task automatic test_no_idling();
		calm = 1'b1;
		run_phase(SIZE_W'(4), 160);
	endtask

	always @(posedge clk) begin
		if (stall_run > 1) begin
			stall_run <= stall_run - 1;
		end else if (!calm && $urandom_range(0, 2) == 0) begin
			out_stall <= 1'b1;
			stall_run <= $urandom_range(1, 18);
		end else begin
			out_stall <= 1'b0;
			stall_run <= calm ? 1 : $urandom_range(1, 40);
		end
	end

	always @(posedge clk) begin : check_results
		colour_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_colours.size() == 0) begin
				$display("%0t: result with none expected: colour_index %0d memo_hit %0b",
					$time, colour_index, memo_hit);
				mismatches++;
			end else begin
				want = expected_colours.pop_front();
				if (colour_index !== want.colour_index) begin
					$display("%0t: colour_index expected %0d actual %0d",
						$time, want.colour_index, colour_index);
					mismatches++;
				end
				if (memo_hit !== want.memo_hit) begin
					$display("%0t: memo_hit expected %0b actual %0b",
						$time, want.memo_hit, memo_hit);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, expected_colours.size());
			$display("status: fail");
			$finish;
		end else begin
			cycle_count <= cycle_count + 1;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_size();
		test_tie_break();
		test_zero_size();
		test_stale_memo();
		test_full_palette();
		test_oversized_size();
		test_random_sizes();
		test_no_idling();
		settle();
		repeat (30) @(posedge clk);
		if (mismatches == 0 && expected_colours.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/npq_pkg.sv
rtl/npq_ram.sv
rtl/npq_search.sv
rtl/nearest_palette_quantizer.sv
tb/sv/nearest_palette_quantizer_tb.sv
